/* hdl/q2e_pkg.sv */
// Shared types, widths and constants for the quaternion to Z-Y-X Euler converter.
// Used by the square-root cells, the CORDIC cells and the top level.
package q2e_pkg;

   localparam int OpW         = 38;
   localparam int AngW        = 20;
   localparam int RadW        = 58;
   localparam int RemW        = 32;
   localparam int RootW       = 29;
   localparam int SlimW       = 30;
   localparam int SqrtSteps   = 29;
   localparam int CordicSteps = 17;
   localparam int FrontStages = 3;
   localparam int PipeStages  = FrontStages + SqrtSteps + 1 + CordicSteps;

   localparam logic signed [AngW-1:0]  PiQ16      = 20'sd205887;
   localparam logic signed [SlimW-1:0] OneQ28     = 30'sd268435456;
   localparam logic signed [16:0]      AngPiQ13   = 17'sd25736;
   localparam logic signed [16:0]      AngHalfPiQ13 = 17'sd12868;

   typedef struct packed {
      logic signed [OpW-1:0]   yaw_y;
      logic signed [OpW-1:0]   yaw_x;
      logic signed [OpW-1:0]   roll_y;
      logic signed [OpW-1:0]   roll_x;
      logic signed [SlimW-1:0] pitch_s;
   } side_type;

   typedef struct packed {
      logic [RadW-1:0]  rad;
      logic [RemW-1:0]  rem;
      logic [RootW-1:0] root;
      side_type         side;
   } sqrt_stage_type;

   typedef struct packed {
      logic signed [OpW-1:0]  x;
      logic signed [OpW-1:0]  y;
      logic signed [AngW-1:0] z;
      logic                   zero;
   } lane_type;

   function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] idx);
      logic signed [AngW-1:0] v;
      unique case (idx)
         5'd0:  v = 20'sd51472;
         5'd1:  v = 20'sd30386;
         5'd2:  v = 20'sd16055;
         5'd3:  v = 20'sd8150;
         5'd4:  v = 20'sd4091;
         5'd5:  v = 20'sd2047;
         5'd6:  v = 20'sd1024;
         5'd7:  v = 20'sd512;
         5'd8:  v = 20'sd256;
         5'd9:  v = 20'sd128;
         5'd10: v = 20'sd64;
         5'd11: v = 20'sd32;
         5'd12: v = 20'sd16;
         5'd13: v = 20'sd8;
         5'd14: v = 20'sd4;
         5'd15: v = 20'sd2;
         5'd16: v = 20'sd1;
         default: v = 20'sd0;
      endcase
      return v;
   endfunction

endpackage

/* hdl/quaternion_to_euler_zyx.sv */
// Top level of the quaternion to Z-Y-X Euler angle converter.
// Depends on q2e_pkg, q2e_sqrt_cell and q2e_cordic_cell.
//
// Usage:
// The req channel carries one quaternion (x, y, z, w, signed Q2.14) per transfer.
// The rsp channel returns yaw and roll in signed Q3.13 radians and pitch in signed
// Q2.13 radians, one transfer per request, in request order.
// Throughput is one transfer per cycle while the receiver does not stall: a row
// of 29 square-root digit cells followed by 17 CORDIC cells per angle, every
// cell taking a new item each cycle.
// The whole pipeline advances together. When the receiver stalls while a result
// is held in the output register, the pipeline freezes and req_stall rises in the
// same cycle; nothing is lost or repeated.
// Reset clears all valid flags; partially processed items are discarded.
// The block holds no configuration and no state between items.
module quaternion_to_euler_zyx import q2e_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_yaw_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_roll_angle
);

   logic adv;
   logic [PipeStages-1:0] vld_ff, vld_in;
   logic rsp_valid_ff;

   logic signed [31:0] xx_ff, yy_ff, zz_ff, ww_ff, xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   side_type side2_ff, side2_in;
   logic signed [OpW-1:0] s_full;
   side_type side3_ff;
   logic [RadW-1:0] rad3_ff, rad3_in;
   logic [RootW-1:0] mag;
   logic [RadW-1:0] mag_sq;

   sqrt_stage_type sq_d [SqrtSteps+1];
   lane_type yaw_l [CordicSteps+1];
   lane_type pit_l [CordicSteps+1];
   lane_type rol_l [CordicSteps+1];
   lane_type yaw_p_ff, pit_p_ff, rol_p_ff;

   logic signed [15:0] yaw_ff, roll_ff;
   logic signed [14:0] pitch_ff;
   logic signed [16:0] yaw_sat, pitch_sat, roll_sat;

   function automatic lane_type prep(input logic signed [OpW-1:0] y,
                                     input logic signed [OpW-1:0] x);
      lane_type l;
      l.zero = (x == '0) && (y == '0);
      if (x[OpW-1]) begin
         l.z = y[OpW-1] ? -PiQ16 : PiQ16;
         l.x = -x;
         l.y = -y;
      end else begin
         l.z = '0;
         l.x = x;
         l.y = y;
      end
      return l;
   endfunction

   function automatic logic signed [16:0] finish(input lane_type l,
                                                 input logic signed [16:0] lim);
      logic signed [AngW-1:0] zr;
      logic signed [16:0] a;
      zr = (l.z + 20'sd4) >>> 3;
      a  = zr[16:0];
      if (l.zero) begin
         a = '0;
      end else if (a > lim) begin
         a = lim;
      end else if (a < -lim) begin
         a = -lim;
      end
      return a;
   endfunction

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[PipeStages-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[PipeStages-1];
      end
   end

   always_comb begin
      side2_in.yaw_y  = (38'(xy_ff) + 38'(wz_ff)) <<< 1;
      side2_in.yaw_x  = 38'(ww_ff) + 38'(xx_ff) - 38'(yy_ff) - 38'(zz_ff);
      side2_in.roll_y = (38'(yz_ff) + 38'(wx_ff)) <<< 1;
      side2_in.roll_x = 38'(ww_ff) - 38'(xx_ff) - 38'(yy_ff) + 38'(zz_ff);
      s_full = -((38'(xz_ff) - 38'(wy_ff)) <<< 1);
      if (s_full > 38'(OneQ28)) begin
         side2_in.pitch_s = OneQ28;
      end else if (s_full < -38'(OneQ28)) begin
         side2_in.pitch_s = -OneQ28;
      end else begin
         side2_in.pitch_s = s_full[SlimW-1:0];
      end
   end

   always_comb begin
      mag     = side2_ff.pitch_s[SlimW-1] ? RootW'(-side2_ff.pitch_s) :
                                            RootW'(side2_ff.pitch_s);
      mag_sq  = RadW'(mag) * RadW'(mag);
      rad3_in = (RadW'(1) << 56) - mag_sq;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xx_ff    <= req_quat_x * req_quat_x;
         yy_ff    <= req_quat_y * req_quat_y;
         zz_ff    <= req_quat_z * req_quat_z;
         ww_ff    <= req_quat_w * req_quat_w;
         xy_ff    <= req_quat_x * req_quat_y;
         wz_ff    <= req_quat_w * req_quat_z;
         xz_ff    <= req_quat_x * req_quat_z;
         wy_ff    <= req_quat_w * req_quat_y;
         yz_ff    <= req_quat_y * req_quat_z;
         wx_ff    <= req_quat_w * req_quat_x;
         side2_ff <= side2_in;
         side3_ff <= side2_ff;
         rad3_ff  <= rad3_in;
      end
   end

   assign sq_d[0] = {rad3_ff, {RemW{1'b0}}, {RootW{1'b0}}, side3_ff};

   for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
      q2e_sqrt_cell u_cell (
         .clock (clock),
         .adv   (adv),
         .d_in  (sq_d[k]),
         .d_out (sq_d[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         yaw_p_ff <= prep(sq_d[SqrtSteps].side.yaw_y, sq_d[SqrtSteps].side.yaw_x);
         pit_p_ff <= prep(OpW'(sq_d[SqrtSteps].side.pitch_s),
                          $signed({{(OpW-RootW){1'b0}}, sq_d[SqrtSteps].root}));
         rol_p_ff <= prep(sq_d[SqrtSteps].side.roll_y, sq_d[SqrtSteps].side.roll_x);
      end
   end

   assign yaw_l[0] = yaw_p_ff;
   assign pit_l[0] = pit_p_ff;
   assign rol_l[0] = rol_p_ff;

   for (genvar k = 0; k < CordicSteps; k++) begin : g_cordic
      q2e_cordic_cell u_yaw (
         .clock (clock), .adv (adv), .step_idx (5'(k)),
         .d_in (yaw_l[k]), .d_out (yaw_l[k+1])
      );
      q2e_cordic_cell u_pitch (
         .clock (clock), .adv (adv), .step_idx (5'(k)),
         .d_in (pit_l[k]), .d_out (pit_l[k+1])
      );
      q2e_cordic_cell u_roll (
         .clock (clock), .adv (adv), .step_idx (5'(k)),
         .d_in (rol_l[k]), .d_out (rol_l[k+1])
      );
   end

   always_comb begin
      yaw_sat   = finish(yaw_l[CordicSteps], AngPiQ13);
      pitch_sat = finish(pit_l[CordicSteps], AngHalfPiQ13);
      roll_sat  = finish(rol_l[CordicSteps], AngPiQ13);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         yaw_ff   <= yaw_sat[15:0];
         pitch_ff <= pitch_sat[14:0];
         roll_ff  <= roll_sat[15:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_yaw_angle   = yaw_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_roll_angle  = roll_ff;

endmodule

/* hdl/q2e_sqrt_cell.sv */
// One digit step of the pipelined integer square root, with side data carried along.
// Depends on q2e_pkg.
module q2e_sqrt_cell import q2e_pkg::*; (
   input  logic           clock,
   input  logic           adv,
   input  sqrt_stage_type d_in,
   output sqrt_stage_type d_out
);

   sqrt_stage_type stage_ff, stage_in;
   logic [RemW-1:0] rem2;
   logic [RemW-1:0] trial;

   always_comb begin
      rem2  = {d_in.rem[RemW-3:0], d_in.rad[RadW-1 -: 2]};
      trial = {1'b0, d_in.root, 2'b01};
      stage_in      = d_in;
      stage_in.rad  = {d_in.rad[RadW-3:0], 2'b00};
      if (rem2 >= trial) begin
         stage_in.rem  = rem2 - trial;
         stage_in.root = {d_in.root[RootW-2:0], 1'b1};
      end else begin
         stage_in.rem  = rem2;
         stage_in.root = {d_in.root[RootW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign d_out = stage_ff;

endmodule

/* hdl/q2e_cordic_cell.sv */
// One vectoring CORDIC rotation for a single atan2 lane, registered.
// Depends on q2e_pkg for the lane type and the arctangent table.
module q2e_cordic_cell import q2e_pkg::*; (
   input  logic     clock,
   input  logic     adv,
   input  logic [4:0] step_idx,
   input  lane_type d_in,
   output lane_type d_out
);

   lane_type lane_ff, lane_in;
   logic signed [OpW-1:0] dx;
   logic signed [OpW-1:0] dy;

   always_comb begin
      dx = d_in.y >>> step_idx;
      dy = d_in.x >>> step_idx;
      lane_in = d_in;
      if (!d_in.y[OpW-1]) begin
         lane_in.x = d_in.x + dx;
         lane_in.y = d_in.y - dy;
         lane_in.z = d_in.z + atan_entry(step_idx);
      end else begin
         lane_in.x = d_in.x - dx;
         lane_in.y = d_in.y + dy;
         lane_in.z = d_in.z - atan_entry(step_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in;
      end
   end

   assign d_out = lane_ff;

endmodule

/* hdl/q2e_checker.sv */
// Port-level checks for the quaternion to Euler converter, bound to the top level.
// Depends on the top level's port list only.
module q2e_port_checks (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_yaw_angle,
   input logic signed [14:0] rsp_pitch_angle,
   input logic signed [15:0] rsp_roll_angle
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Result withdrawn while the receiver stalled.");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_yaw_angle) && $stable(rsp_roll_angle))
      else $error("Stalled result changed.");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("Request transfer possible while the output is held.");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_yaw_angle <= 16'sd25736 && rsp_yaw_angle >= -16'sd25736 &&
                    rsp_pitch_angle <= 15'sd12868 && rsp_pitch_angle >= -15'sd12868)
      else $error("Angle out of range.");

endmodule

bind quaternion_to_euler_zyx q2e_port_checks u_q2e_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_yaw_angle   (rsp_yaw_angle),
   .rsp_pitch_angle (rsp_pitch_angle),
   .rsp_roll_angle  (rsp_roll_angle)
);
